// ----- src/nnrs_pkg.sv -----
// Shared types, codes and default sizes of the nearest-neighbor row scaler.
// No dependencies; nnrs_ctrl, nnrs_outq, the top level and the testbench import this package.
`default_nettype none

package nnrs_pkg;

  localparam int DEF_MAX_IN_WIDTH = 1024;
  localparam int DEF_FRAC_BITS    = 16;
  localparam int OUTQ_DEPTH       = 4;

  localparam int MAX_IN_HEIGHT  = 4096;
  localparam int MAX_OUT_WIDTH  = 16384;
  localparam int CFG_DATA_W     = 20;
  localparam int CFG_INDEX_W    = 3;
  localparam int PIX_W          = 24;
  localparam int STATUS_W       = 3;
  localparam int ACC_W          = 32;

  // Item status codes.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PIXEL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PAD      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd4;

  localparam logic [PIX_W-1:0] PAD_VALUE = 24'h000000;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INPUT_WIDTH   = 3'd0,
    CFG_INPUT_HEIGHT  = 3'd1,
    CFG_OUTPUT_WIDTH  = 3'd2,
    CFG_OUTPUT_HEIGHT = 3'd3,
    CFG_INVERSE_SCALE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] input_width;
    logic [12:0] input_height;
    logic [14:0] output_width;
    logic [15:0] output_height;
    logic [19:0] inverse_scale;
  } cfg_t;

  // Result fields known at issue time; pixel data joins in the next cycle, from the registered read.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                row_end;
    logic                frame_end;
  } meta_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PIX_W-1:0]    pixel;
    logic                row_end;
    logic                frame_end;
  } result_t;

endpackage

`default_nettype wire

// ----- src/nnrs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the line store.
`default_nettype none

module nnrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/nnrs_ctrl.sv -----
// Issue stage of the scaler: buffer bookkeeping, row/column mapping and
// line-store access. Depends on nnrs_pkg; drives the nnrs_ram ports.
`default_nettype none

module nnrs_ctrl #(
  parameter int MAX_IN_WIDTH = nnrs_pkg::DEF_MAX_IN_WIDTH,
  parameter int FRAC_BITS    = nnrs_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire nnrs_pkg::cfg_t                       cfg,
  input  wire logic                                 accept,
  input  wire logic                                 operation,
  input  wire logic [nnrs_pkg::PIX_W-1:0]           pixel_in,
  output logic                                      ram_we,
  output logic [$clog2(2*MAX_IN_WIDTH)-1:0]         ram_waddr,
  output logic [nnrs_pkg::PIX_W-1:0]                ram_wdata,
  output logic                                      ram_re,
  output logic [$clog2(2*MAX_IN_WIDTH)-1:0]         ram_raddr,
  output logic                                      res_valid,
  output nnrs_pkg::meta_t                           res
);

  import nnrs_pkg::*;

  localparam int AW  = $clog2(MAX_IN_WIDTH);
  localparam int RAW = $clog2(2 * MAX_IN_WIDTH);
  localparam int CW  = $clog2(MAX_IN_WIDTH + 1);

  // State
  logic [1:0]       buffer_ready, buffer_ready_next;
  logic             fill_select, fill_select_next;
  logic             drain_select, drain_select_next;
  logic [AW-1:0]    input_column, input_column_next;
  logic [11:0]      input_row, input_row_next;
  logic [13:0]      output_column, output_column_next;
  logic [15:0]      output_row, output_row_next;
  logic [ACC_W-1:0] column_accumulator, column_accumulator_next;
  logic [ACC_W-1:0] row_accumulator, row_accumulator_next;
  logic [1:0]       pad_remaining, pad_remaining_next;
  meta_t            meta;

  // Effective sizes
  logic [CW-1:0]  iw;
  logic [AW-1:0]  iw_m1;
  logic [12:0]    ih;
  logic [11:0]    ih_m1;
  logic [14:0]    ow;
  logic [15:0]    oh;

  always_comb begin
    if (cfg.input_width == '0) begin
      iw = CW'(1);
    end else if (32'(cfg.input_width) > 32'(MAX_IN_WIDTH)) begin
      iw = CW'(MAX_IN_WIDTH);
    end else begin
      iw = CW'(cfg.input_width);
    end
    iw_m1 = AW'(iw - CW'(1));

    if (cfg.input_height == '0) begin
      ih = 13'd1;
    end else if (cfg.input_height > 13'(MAX_IN_HEIGHT)) begin
      ih = 13'(MAX_IN_HEIGHT);
    end else begin
      ih = cfg.input_height;
    end
    ih_m1 = 12'(ih - 13'd1);

    if (cfg.output_width == '0) begin
      ow = 15'd1;
    end else if (cfg.output_width > 15'(MAX_OUT_WIDTH)) begin
      ow = 15'(MAX_OUT_WIDTH);
    end else begin
      ow = cfg.output_width;
    end

    oh = (cfg.output_height == '0) ? 16'd1 : cfg.output_height;
  end

  function automatic logic [11:0] row_dist(input logic [11:0] row, input logic [12:0] h,
                                           input logic [1:0] k);
    logic [12:0] r;
    r = {1'b0, row};
    if (r >= {11'b0, k}) begin
      return 12'(r - {11'b0, k});
    end
    return 12'(r + h - {11'b0, k});
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [19:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + (ACC_W + 1)'(b);
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  // Source row wanted by the current output row
  logic [ACC_W-1:0] row_hi;
  logic [11:0]      want;
  logic [1:0]       k1, k2;
  logic             try1, hit1, try2, hit2, found;
  logic [1:0]       rdy_a, rdy_s;
  logic             ds_a, ds_s;

  always_comb begin
    row_hi = row_accumulator >> FRAC_BITS;
    want   = (row_hi > ACC_W'(ih_m1)) ? ih_m1 : row_hi[11:0];
    k1     = 2'(buffer_ready[0]) + 2'(buffer_ready[1]);
    k2     = k1 - 2'd1;
    try1   = buffer_ready[drain_select];
    hit1   = try1 && (row_dist(input_row, ih, k1) == want);
    rdy_a  = buffer_ready & ~(2'b01 << drain_select);
    ds_a   = ~drain_select;
    try2   = try1 && !hit1 && rdy_a[ds_a];
    hit2   = try2 && (row_dist(input_row, ih, k2) == want);
    found  = hit1 || hit2;
    // Drop mismatching buffers, up to both of them
    if (!try1 || hit1) begin
      rdy_s = buffer_ready;
      ds_s  = drain_select;
    end else if (try2 && !hit2) begin
      rdy_s = rdy_a & ~(2'b01 << ds_a);
      ds_s  = drain_select;
    end else begin
      rdy_s = rdy_a;
      ds_s  = ds_a;
    end
  end

  // Next-state and line-store access
  logic [AW-1:0]    col;
  logic [CW-1:0]    col_inc;
  logic [12:0]      in_row_inc;
  logic [ACC_W-1:0] col_hi;
  logic [AW-1:0]    src;
  logic [14:0]      out_col_inc;
  logic [16:0]      out_row_inc;
  logic             eor;

  always_comb begin
    buffer_ready_next       = buffer_ready;
    fill_select_next        = fill_select;
    drain_select_next       = drain_select;
    input_column_next       = input_column;
    input_row_next          = input_row;
    output_column_next      = output_column;
    output_row_next         = output_row;
    column_accumulator_next = column_accumulator;
    row_accumulator_next    = row_accumulator;
    pad_remaining_next      = pad_remaining;
    meta                    = '{status: ST_NOTHING, row_end: 1'b0, frame_end: 1'b0};
    eor                     = 1'b0;

    col        = (CW'(input_column) < iw) ? input_column : iw_m1;
    col_inc    = CW'(col) + CW'(1);
    in_row_inc = {1'b0, input_row} + 13'd1;
    col_hi     = column_accumulator >> FRAC_BITS;
    src        = (col_hi > ACC_W'(iw_m1)) ? iw_m1 : col_hi[AW-1:0];
    out_col_inc = {1'b0, output_column} + 15'd1;
    out_row_inc = {1'b0, output_row} + 17'd1;

    ram_we    = 1'b0;
    ram_waddr = RAW'(col) + (fill_select ? RAW'(MAX_IN_WIDTH) : RAW'(0));
    ram_wdata = pixel_in;
    ram_re    = 1'b0;
    ram_raddr = RAW'(src) + (ds_s ? RAW'(MAX_IN_WIDTH) : RAW'(0));

    if (accept) begin
      if (operation == OP_PUSH) begin
        if (buffer_ready[fill_select]) begin
          meta.status = ST_REJECTED;
        end else begin
          meta.status = ST_ACCEPTED;
          ram_we      = 1'b1;
          if (col_inc >= iw) begin
            input_column_next = '0;
            buffer_ready_next = buffer_ready | (2'b01 << fill_select);
            fill_select_next  = ~fill_select;
            input_row_next    = (in_row_inc >= ih) ? 12'd0 : in_row_inc[11:0];
          end else begin
            input_column_next = col_inc[AW-1:0];
          end
        end
      end else if (pad_remaining != 2'd0) begin
        meta.status        = ST_PAD;
        pad_remaining_next = pad_remaining - 2'd1;
        if (pad_remaining == 2'd1) begin
          meta.row_end = 1'b1;
          eor          = 1'b1;
        end
      end else begin
        buffer_ready_next = rdy_s;
        drain_select_next = ds_s;
        if (found) begin
          meta.status = ST_PIXEL;
          ram_re      = 1'b1;
          if (out_col_inc >= ow) begin
            output_column_next      = '0;
            column_accumulator_next = '0;
            // 3 * ow bytes need ow mod 4 pad bytes to reach a 4-byte boundary
            pad_remaining_next      = ow[1:0];
            if (ow[1:0] == 2'd0) begin
              meta.row_end = 1'b1;
              eor          = 1'b1;
            end
          end else begin
            output_column_next      = out_col_inc[13:0];
            column_accumulator_next = sat_add(column_accumulator, cfg.inverse_scale);
          end
        end
      end

      if (eor) begin
        if (out_row_inc >= {1'b0, oh}) begin
          meta.frame_end       = 1'b1;
          output_row_next      = '0;
          row_accumulator_next = '0;
          if (buffer_ready_next[drain_select_next]) begin
            buffer_ready_next = buffer_ready_next & ~(2'b01 << drain_select_next);
            drain_select_next = ~drain_select_next;
          end
        end else begin
          output_row_next      = out_row_inc[15:0];
          row_accumulator_next = sat_add(row_accumulator, cfg.inverse_scale);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_ready       <= '0;
      fill_select        <= 1'b0;
      drain_select       <= 1'b0;
      input_column       <= '0;
      input_row          <= '0;
      output_column      <= '0;
      output_row         <= '0;
      column_accumulator <= '0;
      row_accumulator    <= '0;
      pad_remaining      <= '0;
      res_valid          <= 1'b0;
    end else begin
      buffer_ready       <= buffer_ready_next;
      fill_select        <= fill_select_next;
      drain_select       <= drain_select_next;
      input_column       <= input_column_next;
      input_row          <= input_row_next;
      output_column      <= output_column_next;
      output_row         <= output_row_next;
      column_accumulator <= column_accumulator_next;
      row_accumulator    <= row_accumulator_next;
      pad_remaining      <= pad_remaining_next;
      res_valid          <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= meta;
    end
  end

  // A fill never lands in a buffer that is waiting to drain
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !buffer_ready[ram_waddr >= RAW'(MAX_IN_WIDTH)])
    else $error("line store write into a ready buffer");

  // Pad bytes only follow a completed row of pixels
  assert property (@(posedge clk) disable iff (rst)
    pad_remaining != 2'd0 |-> output_column == '0 && column_accumulator == '0)
    else $error("pad pending in the middle of a row");

  // A pixel result always has line-store data behind it
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_PIXEL |-> $past(ram_re))
    else $error("pixel result without a line-store read");

endmodule

`default_nettype wire

// ----- src/nnrs_outq.sv -----
// Small result queue that decouples the issue stage from output stalls.
// Depends on nnrs_pkg for the result type.
`default_nettype none

module nnrs_outq #(
  parameter int DEPTH = nnrs_pkg::OUTQ_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire nnrs_pkg::result_t          push_data,
  input  wire logic                       pop,
  output logic [$clog2(DEPTH+1)-1:0]      count,
  output nnrs_pkg::result_t               head
);

  import nnrs_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  result_t       entries [DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (32'(p) == DEPTH - 1) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head = entries[rd_ptr];

  assert property (@(posedge clk) disable iff (rst)
    push |-> count < NW'(DEPTH) || pop)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("result queue underflow");

  assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

// ----- src/nearest_neighbor_row_scaler.sv -----
// Nearest-neighbor row scaler for 24-bit pixels: top level.
// Depends on nnrs_pkg, nnrs_ram, nnrs_ctrl and nnrs_outq.
//
// Every accepted item (push a pixel or pull an output item) yields exactly one
// result item. Throughput is one item per clock while in_stall is low: the
// issue stage decides the item in the cycle it is accepted and, for a pixel
// pick, starts a line-store read; the result is complete in the next cycle,
// when the registered read data returns, and is written into a four-entry
// result queue. A result shows on out_valid once the queue holds it and
// leaves while out_stall is low. in_stall rises only when
// the queue plus the item in flight fill all four entries, so a consumer that
// takes one result per clock never stalls the input. The line store is one
// RAM of 2 x MAX_IN_WIDTH pixels (two ping-pong line buffers); a push writes
// only a buffer that is not ready and a pull reads only a ready buffer, so a
// read and a write never touch the same entry and no forwarding is needed.
// Output column c maps to source column floor(c * inverse_scale / 2^FRAC_BITS),
// row r likewise, both through saturating accumulators. Configuration writes
// land immediately and must come only while the block is idle.
`default_nettype none

module nearest_neighbor_row_scaler #(
  parameter int MAX_IN_WIDTH = nnrs_pkg::DEF_MAX_IN_WIDTH,
  parameter int FRAC_BITS    = nnrs_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic [nnrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [nnrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              operation,
  input  wire logic [nnrs_pkg::PIX_W-1:0]        pixel_in,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [nnrs_pkg::STATUS_W-1:0]          status,
  output logic [nnrs_pkg::PIX_W-1:0]             pixel_out,
  output logic                                   row_end,
  output logic                                   frame_end
);

  import nnrs_pkg::*;

  localparam int RAW = $clog2(2 * MAX_IN_WIDTH);
  localparam int NW  = $clog2(OUTQ_DEPTH + 1);

  cfg_t cfg;

  // Registers take the low bits of the write data; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_width   <= 11'd1;
      cfg.input_height  <= 13'd1;
      cfg.output_width  <= 15'd1;
      cfg.output_height <= 16'd1;
      cfg.inverse_scale <= 20'h10000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INPUT_WIDTH:   cfg.input_width   <= cfg_data[10:0];
        CFG_INPUT_HEIGHT:  cfg.input_height  <= cfg_data[12:0];
        CFG_OUTPUT_WIDTH:  cfg.output_width  <= cfg_data[14:0];
        CFG_OUTPUT_HEIGHT: cfg.output_height <= cfg_data[15:0];
        CFG_INVERSE_SCALE: cfg.inverse_scale <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  logic             in_accept, out_accept;
  logic             ram_we, ram_re;
  logic [RAW-1:0]   ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;
  logic             res_valid;
  meta_t            res;
  result_t          q_in, q_head;
  logic [NW-1:0]    q_count;
  logic [NW:0]      occupancy;

  // Hold input while the queue and the item in flight would fill it
  assign occupancy  = {1'b0, q_count} + (NW + 1)'(res_valid);
  assign in_stall   = occupancy >= (NW + 1)'(OUTQ_DEPTH);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = q_count != '0;
  assign out_accept = out_valid && !out_stall;

  nnrs_ctrl #(
    .MAX_IN_WIDTH (MAX_IN_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (in_accept),
    .operation (operation),
    .pixel_in  (pixel_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res_valid (res_valid),
    .res       (res)
  );

  nnrs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (2 * MAX_IN_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Merge returning read data; every non-pixel result carries zero
  always_comb begin
    q_in.status    = res.status;
    q_in.pixel     = (res.status == ST_PIXEL) ? ram_rdata : PAD_VALUE;
    q_in.row_end   = res.row_end;
    q_in.frame_end = res.frame_end;
  end

  nnrs_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (q_in),
    .pop       (out_accept),
    .count     (q_count),
    .head      (q_head)
  );

  assign status    = q_head.status;
  assign pixel_out = q_head.pixel;
  assign row_end   = q_head.row_end;
  assign frame_end = q_head.frame_end;

  // An accepted item always has room reserved in the queue
  assert property (@(posedge clk) disable iff (rst)
    in_accept |-> occupancy < (NW + 1)'(OUTQ_DEPTH))
    else $error("item accepted without queue room");

  // frame_end only ever marks the last item of a row
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // Each accepted item produces its result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> res_valid)
    else $error("accepted item produced no result");

endmodule

`default_nettype wire

// ----- tb/tb_nearest_neighbor_row_scaler.sv -----
// Self-checking testbench for the nearest-neighbor row scaler.
// Needs nnrs_pkg and the scaler RTL; an internal line-buffer predictor checks every result item.
`timescale 1ns / 100ps

module tb_nearest_neighbor_row_scaler;
  import nnrs_pkg::*;

  localparam int MAX_W          = DEF_MAX_IN_WIDTH;
  localparam int FRAC           = DEF_FRAC_BITS;
  localparam int MAX_OUT_HEIGHT = 65535;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int QUIET_TAIL     = 150;
  localparam int CLAMP_PUSHES   = 4;
  localparam int WIDE_PULLS     = 48;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 1_000_000;

  // One row of the directed table: the item, and a hand-written result where
  // the result is obvious; otherwise the predictor supplies it.
  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
    logic             typed_in;
    result_t          want;
  } stim_row_t;

  localparam result_t FROM_PREDICTOR = '0;
  localparam int DIRECTED_COUNT = 18;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // right after reset nothing is buffered
    '{OP_PULL, 24'h000000, 1'b1, '{ST_NOTHING, PAD_VALUE, 1'b0, 1'b0}},
    // one-pixel rows: each push completes a line buffer
    '{OP_PUSH, 24'hFFFFFF, 1'b1, '{ST_ACCEPTED, PAD_VALUE, 1'b0, 1'b0}},
    '{OP_PUSH, 24'h000000, 1'b1, '{ST_ACCEPTED, PAD_VALUE, 1'b0, 1'b0}},
    // both buffers are full now
    '{OP_PUSH, 24'hA5A5A5, 1'b1, '{ST_REJECTED, PAD_VALUE, 1'b0, 1'b0}},
    // the oldest buffer holds the wrong row: release it, pick from the other
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    // one pad byte closes the row and the frame
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PUSH, 24'h800001, 1'b0, FROM_PREDICTOR},
    '{OP_PUSH, 24'h7FFFFE, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PUSH, 24'h5A5A5A, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'hFFFFFF, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PUSH, 24'h000001, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR},
    '{OP_PULL, 24'h000000, 1'b0, FROM_PREDICTOR}
  };

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic                   operation = OP_PUSH;
  logic [PIX_W-1:0]       pixel_in  = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [PIX_W-1:0]       pixel_out;
  logic                   row_end;
  logic                   frame_end;

  nearest_neighbor_row_scaler u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .pixel_out (pixel_out),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the size registers and the scaler state, starting from reset.
  cfg_t             regs       = {11'd1, 13'd1, 15'd1, 16'd1, 20'd65536};
  logic [PIX_W-1:0] line_copy [2*MAX_W];
  logic [1:0]       ready_bufs = 2'b00;
  logic             fill_buf   = 1'b0;
  logic             drain_buf  = 1'b0;
  logic [31:0]      in_col     = '0;
  logic [31:0]      in_row     = '0;
  logic [31:0]      out_col    = '0;
  logic [31:0]      out_row    = '0;
  logic [31:0]      col_acc    = '0;
  logic [31:0]      row_acc    = '0;
  logic [1:0]       pads_left  = 2'b00;

  // Result items owed by the block, oldest first.
  result_t results_due [$];

  bit          quiet        = 1'b0;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned checked      = 0;
  int unsigned n_pixels     = 0;
  int unsigned n_pads       = 0;
  int unsigned n_frames     = 0;
  int unsigned n_rejects    = 0;
  int unsigned n_settings   = 0;
  result_t     oldest;
  result_t     arrived;

  function automatic logic [31:0] clamp32(input logic [31:0] v, input logic [31:0] lo,
                                          input logic [31:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void free_drain_buffer();
    ready_bufs[drain_buf] = 1'b0;
    drain_buf = ~drain_buf;
  endfunction

  // Step to the next output row; wrap the frame and free its buffer at the end.
  function automatic logic close_output_row();
    logic [31:0] oh;
    oh = clamp32(32'(regs.output_height), 1, MAX_OUT_HEIGHT);
    out_row = out_row + 1;
    row_acc = sat_add32(row_acc, 32'(regs.inverse_scale));
    if (out_row >= oh) begin
      out_row = 0;
      row_acc = 0;
      if (ready_bufs[drain_buf]) free_drain_buffer();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the result item of one accepted item and advance the shadow state.
  function automatic result_t next_scaler_result(input logic op, input logic [PIX_W-1:0] pix);
    result_t     r;
    logic [31:0] iw, ih, ow, col, k, d, want, src, padn;
    logic        found;
    iw = clamp32(32'(regs.input_width), 1, MAX_W);
    ih = clamp32(32'(regs.input_height), 1, MAX_IN_HEIGHT);
    ow = clamp32(32'(regs.output_width), 1, MAX_OUT_WIDTH);
    r = '0;
    r.status = ST_NOTHING;
    r.pixel = PAD_VALUE;
    if (op == OP_PUSH) begin
      if (ready_bufs[fill_buf]) begin
        r.status = ST_REJECTED;
      end else begin
        // a column left beyond a shrunk width lands on the last column
        col = (in_col < iw) ? in_col : iw - 1;
        line_copy[int'(fill_buf) * MAX_W + int'(col)] = pix;
        in_col = col + 1;
        if (in_col >= iw) begin
          in_col = 0;
          ready_bufs[fill_buf] = 1'b1;
          fill_buf = ~fill_buf;
          in_row = in_row + 1;
          if (in_row >= ih) in_row = 0;
        end
        r.status = ST_ACCEPTED;
      end
    end else if (pads_left != 2'b00) begin
      r.status = ST_PAD;
      pads_left = pads_left - 2'd1;
      if (pads_left == 2'b00) begin
        r.row_end = 1'b1;
        r.frame_end = close_output_row();
      end
    end else begin
      // drop ready buffers whose source row is not the one wanted, at most two
      found = 1'b0;
      for (int t = 0; t < 2 && !found && ready_bufs[drain_buf]; t++) begin
        k = 32'(ready_bufs[0]) + 32'(ready_bufs[1]);
        d = (in_row >= k) ? in_row - k : in_row + ih - k;
        want = row_acc >> FRAC;
        if (want > ih - 1) want = ih - 1;
        if (d == want) found = 1'b1;
        else free_drain_buffer();
      end
      if (found) begin
        src = col_acc >> FRAC;
        if (src > iw - 1) src = iw - 1;
        r.status = ST_PIXEL;
        r.pixel = line_copy[int'(drain_buf) * MAX_W + int'(src)];
        out_col = out_col + 1;
        col_acc = sat_add32(col_acc, 32'(regs.inverse_scale));
        if (out_col >= ow) begin
          out_col = 0;
          col_acc = 0;
          padn = (32'd4 - ((ow * 32'd3) & 32'd3)) & 32'd3;
          pads_left = padn[1:0];
          if (padn == 0) begin
            r.row_end = 1'b1;
            r.frame_end = close_output_row();
          end
        end
      end
    end
    return r;
  endfunction

  // Present one item, hold it until accepted, then record the result it owes.
  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix, input logic typed_in,
                           input result_t typed_want, output result_t predicted);
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    pixel_in  <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_scaler_result(op, pix);
    results_due.push_back(typed_in ? typed_want : predicted);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_write after the last one.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_INPUT_WIDTH:   regs.input_width   = val[10:0];
      CFG_INPUT_HEIGHT:  regs.input_height  = val[12:0];
      CFG_OUTPUT_WIDTH:  regs.output_width  = val[14:0];
      CFG_OUTPUT_HEIGHT: regs.output_height = val[15:0];
      CFG_INVERSE_SCALE: regs.inverse_scale = val[19:0];
      default: ;
    endcase
  endtask

  task automatic load_sizes(input logic [CFG_DATA_W-1:0] iw, input logic [CFG_DATA_W-1:0] ih,
                            input logic [CFG_DATA_W-1:0] ow, input logic [CFG_DATA_W-1:0] oh,
                            input logic [CFG_DATA_W-1:0] scale);
    write_reg(CFG_INPUT_WIDTH, iw);
    write_reg(CFG_INPUT_HEIGHT, ih);
    write_reg(CFG_OUTPUT_WIDTH, ow);
    write_reg(CFG_OUTPUT_HEIGHT, oh);
    write_reg(CFG_INVERSE_SCALE, scale);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // Result side: stall in random bursts, none once the quiet tail starts.
  initial begin : result_backpressure
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every result item taken with the oldest one owed, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      arrived = {status, pixel_out, row_end, frame_end};
      if (results_due.size() == 0) begin
        $display("%0t ns: result item with nothing owed: status %0d pixel %h", $time,
                 arrived.status, arrived.pixel);
        error_count++;
      end else begin
        oldest = results_due.pop_front();
        checked++;
        if (oldest.status == ST_PIXEL) n_pixels++;
        if (oldest.status == ST_PAD) n_pads++;
        if (oldest.status == ST_REJECTED) n_rejects++;
        if (oldest.frame_end) n_frames++;
        if (arrived.status !== oldest.status) begin
          $display("%0t ns: status expected %0d, got %0d", $time, oldest.status,
                   arrived.status);
          error_count++;
        end
        if (arrived.pixel !== oldest.pixel) begin
          $display("%0t ns: pixel_out expected %h, got %h", $time, oldest.pixel, arrived.pixel);
          error_count++;
        end
        if (arrived.row_end !== oldest.row_end) begin
          $display("%0t ns: row_end expected %b, got %b", $time, oldest.row_end,
                   arrived.row_end);
          error_count++;
        end
        if (arrived.frame_end !== oldest.frame_end) begin
          $display("%0t ns: frame_end expected %b, got %b", $time, oldest.frame_end,
                   arrived.frame_end);
          error_count++;
        end
      end
    end
  end

  // Hard stop: bounds the slowest correct run many times over.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result items still owed", cycle_count,
               results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    result_t                seen;
    logic                   op;
    logic [PIX_W-1:0]       pix;
    logic [CFG_DATA_W-1:0]  iw_val, ih_val, ow_val, oh_val, scale_val;
    int                     pull_pct, phase_len, productive, sent;

    productive = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset sizes (one-pixel rows, unit scale).
    in_idle_pct  = 20;
    out_idle_pct = 20;
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].typed_in,
                DIRECTED_ROWS[i].want, seen);
    end
    // Empty both line buffers so the clamp checks below start clean.
    while (ready_bufs != 2'b00 || pads_left != 2'b00) begin
      send_item(OP_PULL, '0, 1'b0, FROM_PREDICTOR, seen);
    end
    wait_drained();

    // Out-of-range sizes clamp: a zero width becomes one pixel, the rest go
    // to their largest or smallest. Two one-pixel rows fill both buffers and
    // the pushes after them bounce.
    in_idle_pct  = 5;
    out_idle_pct = 5;
    load_sizes(20'h00000, 20'h01FFF, 20'h07FFF, 20'h00000, 20'hFFFFF);
    for (int i = 0; i < CLAMP_PUSHES; i++) begin
      send_item(OP_PUSH, PIX_W'($urandom), 1'b0, FROM_PREDICTOR, seen);
    end
    // Widest output row at the largest step: every pick lands on the last
    // source column; the row is left open for the next size setting.
    for (int i = 0; i < WIDE_PULLS; i++) begin
      send_item(OP_PULL, PIX_W'($urandom), 1'b0, FROM_PREDICTOR, seen);
    end
    wait_drained();

    // Random phases, each under a fresh size setting, small sizes mostly.
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       iw_val = 20'd0;
        1:       iw_val = 20'h007FF;
        default: iw_val = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      // A ready buffer only holds columns up to the width it was filled at:
      // hold the input width from growing until both buffers are drained.
      if (ready_bufs != 2'b00 &&
          clamp32(32'(iw_val), 1, MAX_W) > clamp32(32'(regs.input_width), 1, MAX_W)) begin
        iw_val = CFG_DATA_W'(regs.input_width);
      end
      case ($urandom_range(0, 9))
        0:       ih_val = 20'd0;
        1:       ih_val = 20'h01FFF;
        default: ih_val = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       ow_val = 20'd0;
        1:       ow_val = CFG_DATA_W'(MAX_OUT_WIDTH);
        default: ow_val = CFG_DATA_W'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 9))
        0:       oh_val = 20'd0;
        1:       oh_val = CFG_DATA_W'(MAX_OUT_HEIGHT);
        default: oh_val = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       scale_val = 20'd0;
        1:       scale_val = 20'hFFFFF;
        2:       scale_val = 20'd4096;
        3:       scale_val = 20'd65536;
        default: scale_val = CFG_DATA_W'($urandom_range(8192, 200000));
      endcase
      load_sizes(iw_val, ih_val, ow_val, oh_val, scale_val);

      case ($urandom_range(0, 2))
        0:       in_idle_pct = 0;
        1:       in_idle_pct = 5;
        default: in_idle_pct = 15;
      endcase
      case ($urandom_range(0, 2))
        0:       out_idle_pct = 0;
        1:       out_idle_pct = 5;
        default: out_idle_pct = 15;
      endcase

      phase_len = $urandom_range(40, 140);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
        // Mostly follow the buffers: fill when empty, drain when full; the
        // rest is plain noise.
        if ($urandom_range(0, 9) == 0) begin
          op = $urandom_range(0, 1) ? OP_PULL : OP_PUSH;
        end else begin
          if (ready_bufs == 2'b11) pull_pct = 85;
          else if (ready_bufs == 2'b00 && pads_left == 2'b00) pull_pct = 10;
          else pull_pct = 50;
          op = ($urandom_range(0, 99) < pull_pct) ? OP_PULL : OP_PUSH;
        end
        case ($urandom_range(0, 7))
          0:       pix = 24'h000000;
          1:       pix = 24'hFFFFFF;
          default: pix = PIX_W'($urandom);
        endcase
        send_item(op, pix, 1'b0, FROM_PREDICTOR, seen);
        sent++;
        if (seen.status == ST_ACCEPTED || seen.status == ST_PIXEL || seen.status == ST_PAD) begin
          productive++;
        end
      end
      wait_drained();
    end

    $display("Checked %0d result items under %0d size settings: %0d pixels, %0d pad bytes,",
             checked, n_settings, n_pixels, n_pads);
    $display("%0d frame ends, %0d rejected pushes, %0d of %0d random items did work, %0d mismatches",
             n_frames, n_rejects, productive, sent, error_count);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/nnrs_pkg.sv
src/nnrs_ram.sv
src/nnrs_ctrl.sv
src/nnrs_outq.sv
src/nearest_neighbor_row_scaler.sv
tb/tb_nearest_neighbor_row_scaler.sv
